// ----- src/braun_min_heap_queue_core_macros.svh -----
// Assertion helpers for the heap queue core.
`ifndef BRAUN_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`define BRAUN_MIN_HEAP_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMHQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMHQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bmhq_pkg.sv -----
package bmhq_pkg;

  // Default sizes
  localparam int CAPACITY_DEF   = 1024;
  localparam int INDEX_BITS_DEF = 24;
  localparam int KEY_BITS_DEF   = 32;

  // Operation codes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_REQUEUE = 2'd1;
  localparam logic [1:0] OP_EXTRACT = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_SKIPPED = 2'd3;

endpackage

// ----- src/bmhq_ram.sv -----
module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/bmhq_cmp.sv -----
module bmhq_cmp #(
  parameter int KEY_BITS = bmhq_pkg::KEY_BITS_DEF
) (
  input  logic [KEY_BITS-1:0] a,
  input  logic [KEY_BITS-1:0] b,
  output logic                lt
);

  // Unsigned strict less-than, shared by sift up and sift down
  assign lt = (a < b);

endmodule

// ----- src/braun_min_heap_queue_core.sv -----
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid, in_stall   | op, node_index, key
// out     | output    | out_valid, out_stall | status, out_index, out_key, occupancy
//
// One operation at a time. Insert walks down through IWALK and ILH for each level,
// then sifts up through IUP and ICMP for each level. Extract walks down through
// EWALK and ELH for each level, then sifts down through DTOP, DL, DR and DMOVE
// for each level (two child reads through one RAM port, then the move).
// Synchronous reset empties the queue; slot memories are not cleared.
// A stalled result holds; no new word is taken until it leaves.
`include "braun_min_heap_queue_core_macros.svh"

module braun_min_heap_queue_core #(
  parameter int CAPACITY   = bmhq_pkg::CAPACITY_DEF,
  parameter int INDEX_BITS = bmhq_pkg::INDEX_BITS_DEF,
  parameter int KEY_BITS   = bmhq_pkg::KEY_BITS_DEF,
  localparam int SLOT_BITS  = $clog2(2 * CAPACITY),
  localparam int CNT_BITS   = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  logic [INDEX_BITS-1:0] node_index,
  input  logic [KEY_BITS-1:0]   key,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [INDEX_BITS-1:0] out_index,
  output logic [KEY_BITS-1:0]   out_key,
  output logic [CNT_BITS-1:0]   occupancy
);

  localparam int ENTRY_BITS = INDEX_BITS + KEY_BITS;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_ROOT   = 17'h00002,
    S_IWALK  = 17'h00004,
    S_ILH    = 17'h00008,
    S_IUP    = 17'h00010,
    S_ICMP   = 17'h00020,
    S_IPUT   = 17'h00040,
    S_EWALK  = 17'h00080,
    S_ELH    = 17'h00100,
    S_ELEAF  = 17'h00200,
    S_DTOP   = 17'h00400,
    S_DL     = 17'h00800,
    S_DR     = 17'h01000,
    S_DMOVE  = 17'h02000,
    S_DPUT   = 17'h04000,
    S_OUT    = 17'h08000,
    S_SPARE  = 17'h10000
  } state_t;

  state_t                state;
  logic [1:0]            cur_op;
  logic [INDEX_BITS-1:0] item_ident;
  logic [KEY_BITS-1:0]   item_cost;
  logic [INDEX_BITS-1:0] best_ident;
  logic [KEY_BITS-1:0]   best_cost;
  logic                  best_left;
  logic                  best_right;
  logic [SLOT_BITS-1:0]  pos;
  logic [CNT_BITS-1:0]   size;
  logic [CNT_BITS-1:0]   count;
  logic [1:0]            status_r;
  logic [INDEX_BITS-1:0] out_index_r;
  logic [KEY_BITS-1:0]   out_key_r;

  logic                  ent_we;
  logic [SLOT_BITS-1:0]  ent_waddr;
  logic [ENTRY_BITS-1:0] ent_wdata;
  logic [SLOT_BITS-1:0]  ent_raddr;
  logic [ENTRY_BITS-1:0] ent_rdata;
  logic                  lh_we;
  logic [SLOT_BITS-1:0]  lh_waddr;
  logic                  lh_wdata;
  logic [SLOT_BITS-1:0]  lh_raddr;
  logic                  lh_rdata;
  logic [KEY_BITS-1:0]   cmp_a;
  logic [KEY_BITS-1:0]   cmp_b;
  logic                  cmp_lt;

  logic [INDEX_BITS-1:0] rd_ident;
  logic [KEY_BITS-1:0]   rd_cost;
  logic [SLOT_BITS-1:0]  pos_left;
  logic [SLOT_BITS-1:0]  pos_right;
  logic [CNT_BITS-1:0]   size_half;
  logic [CNT_BITS-1:0]   size_rest;

  assign rd_ident  = ent_rdata[ENTRY_BITS-1:KEY_BITS];
  assign rd_cost   = ent_rdata[KEY_BITS-1:0];
  assign pos_left  = {pos[SLOT_BITS-2:0], 1'b0};
  assign pos_right = {pos[SLOT_BITS-2:0], 1'b1};
  assign size_half = size >> 1;
  assign size_rest = (size - CNT_BITS'(1)) >> 1;

  bmhq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(2 * CAPACITY)) u_slot_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  bmhq_ram #(.WIDTH(1), .DEPTH(2 * CAPACITY)) u_heavy_ram (
    .clk   (clk),
    .we    (lh_we),
    .waddr (lh_waddr),
    .wdata (lh_wdata),
    .raddr (lh_raddr),
    .rdata (lh_rdata)
  );

  bmhq_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  // Steer memory ports and the shared compare by state
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = pos;
    ent_wdata = {item_ident, item_cost};
    ent_raddr = SLOT_BITS'(1);
    lh_we     = 1'b0;
    lh_waddr  = pos;
    lh_wdata  = ~lh_rdata;
    lh_raddr  = pos;
    cmp_a     = rd_cost;
    cmp_b     = item_cost;
    unique case (state)
      S_IWALK: begin
        if (size == '0) begin
          lh_we    = 1'b1;
          lh_wdata = 1'b0;
        end
      end
      S_ILH, S_ELH: lh_we = 1'b1;
      S_IUP: ent_raddr = pos >> 1;
      S_ICMP: begin
        cmp_a = item_cost;
        cmp_b = rd_cost;
        if (cmp_lt) begin
          ent_we    = 1'b1;
          ent_wdata = ent_rdata;
        end
      end
      S_EWALK: ent_raddr = pos;
      S_DTOP:  ent_raddr = pos_left;
      S_DL:    ent_raddr = pos_right;
      S_DR:    cmp_b = best_cost;
      S_DMOVE: begin
        if (best_left || best_right) begin
          ent_we    = 1'b1;
          ent_wdata = {best_ident, best_cost};
        end
      end
      S_IPUT, S_DPUT: ent_we = 1'b1;
      default: ;
    endcase
  end

  // Sequence one operation
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_op      <= op;
            item_ident  <= node_index;
            item_cost   <= key;
            status_r    <= bmhq_pkg::ST_DONE;
            out_index_r <= '0;
            out_key_r   <= '0;
            state       <= S_ROOT;
          end
        end
        S_ROOT: begin
          pos  <= SLOT_BITS'(1);
          size <= count;
          if (cur_op == bmhq_pkg::OP_EXTRACT) begin
            if (count == '0) begin
              status_r <= bmhq_pkg::ST_EMPTY;
              state    <= S_OUT;
            end else begin
              out_index_r <= rd_ident;
              out_key_r   <= rd_cost;
              state       <= S_EWALK;
            end
          end else if (cur_op == bmhq_pkg::OP_INSERT || cur_op == bmhq_pkg::OP_REQUEUE) begin
            if (cur_op == bmhq_pkg::OP_REQUEUE && count != '0 && rd_ident == item_ident) begin
              status_r <= bmhq_pkg::ST_SKIPPED;
              state    <= S_OUT;
            end else if (count >= CNT_BITS'(CAPACITY)) begin
              status_r <= bmhq_pkg::ST_FULL;
              state    <= S_OUT;
            end else begin
              state <= S_IWALK;
            end
          end else begin
            state <= S_OUT;
          end
        end
        // Insert: walk down flipping balance bits
        S_IWALK: begin
          if (size == '0) begin
            count <= count + CNT_BITS'(1);
            state <= S_IUP;
          end else begin
            state <= S_ILH;
          end
        end
        S_ILH: begin
          pos   <= lh_rdata ? pos_right : pos_left;
          size  <= size_rest;
          state <= S_IWALK;
        end
        // Insert: sift up, moving parents down
        S_IUP: state <= (pos == SLOT_BITS'(1)) ? S_IPUT : S_ICMP;
        S_ICMP: begin
          if (cmp_lt) begin
            pos   <= pos >> 1;
            state <= S_IUP;
          end else begin
            state <= S_IPUT;
          end
        end
        S_IPUT: state <= S_OUT;
        // Extract: walk to the leaf to remove
        S_EWALK: begin
          if (size > CNT_BITS'(1)) begin
            state <= S_ELH;
          end else begin
            count <= count - CNT_BITS'(1);
            state <= (count == CNT_BITS'(1)) ? S_OUT : S_ELEAF;
          end
        end
        S_ELH: begin
          pos   <= lh_rdata ? pos_left : pos_right;
          size  <= lh_rdata ? size_half : size_rest;
          state <= S_EWALK;
        end
        S_ELEAF: begin
          item_ident <= rd_ident;
          item_cost  <= rd_cost;
          pos        <= SLOT_BITS'(1);
          size       <= count;
          state      <= S_DTOP;
        end
        // Extract: sift the moved leaf down from the root
        S_DTOP: state <= (size < CNT_BITS'(2)) ? S_DPUT : S_DL;
        S_DL: begin
          best_right <= 1'b0;
          best_left  <= cmp_lt;
          best_ident <= cmp_lt ? rd_ident : item_ident;
          best_cost  <= cmp_lt ? rd_cost : item_cost;
          state      <= (size_rest >= CNT_BITS'(1)) ? S_DR : S_DMOVE;
        end
        S_DR: begin
          if (cmp_lt) begin
            best_left  <= 1'b0;
            best_right <= 1'b1;
            best_ident <= rd_ident;
            best_cost  <= rd_cost;
          end
          state <= S_DMOVE;
        end
        S_DMOVE: begin
          if (best_left) begin
            pos   <= pos_left;
            size  <= size_half;
            state <= S_DTOP;
          end else if (best_right) begin
            pos   <= pos_right;
            size  <= size_rest;
            state <= S_DTOP;
          end else begin
            state <= S_DPUT;
          end
        end
        S_DPUT: state <= S_OUT;
        // Hold the result word until taken
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign status    = status_r;
  assign out_index = out_index_r;
  assign out_key   = out_key_r;
  assign occupancy = count;

  `BMHQ_ASSERT_IMP(a_no_out_when_idle, !in_stall, !out_valid, "result shown while idle")
  `BMHQ_ASSERT_IMP(a_occ_bound, 1'b1, count <= CNT_BITS'(CAPACITY), "occupancy beyond capacity")
  `BMHQ_ASSERT_IMP(a_empty_is_zero, out_valid && status == bmhq_pkg::ST_EMPTY,
                   occupancy == '0 && out_index == '0, "empty status with items")
  `BMHQ_ASSERT_NXT(a_full_keeps, state == S_ROOT && status_r == bmhq_pkg::ST_DONE
                   && count == CNT_BITS'(CAPACITY) && cur_op == bmhq_pkg::OP_INSERT,
                   count == CNT_BITS'(CAPACITY), "insert on full changed count")

endmodule
